### rtl/core/mlbh_pkg.sv
// ----------------------------------------------------------------------------
// mlbh_pkg: shared types and constants of the four-lane byte hash
// Lane start values, multiplier and mixing constants, and digest types.
// ----------------------------------------------------------------------------
`default_nettype none

package mlbh_pkg;

    localparam int unsigned LaneMax   = 4;
    localparam int unsigned LaneWidth = 64;
    localparam int unsigned ByteWidth = 8;

    typedef logic [LaneWidth-1:0] lane_t;
    typedef logic [ByteWidth-1:0] byte_t;
    typedef lane_t [LaneMax-1:0]  digest_t;

    localparam lane_t LaneStart [LaneMax] = '{
        64'd1469598103934665603,
        64'd1099511628211,
        64'h9e3779b97f4a7c15,
        64'hd6e8feb86659fd93
    };

    localparam lane_t       FnvPrime     = 64'd1099511628211;
    localparam int unsigned PrimeShift   = 40;
    localparam lane_t       PrimeLow     = FnvPrime - (64'd1 << PrimeShift);
    localparam int unsigned LaneAddStep  = 41;
    localparam int unsigned FoldShift    = 29;

endpackage

`default_nettype wire

### rtl/core/mlbh_byte_if.sv
// ----------------------------------------------------------------------------
// mlbh_byte_if: message byte channel
// Valid/ready channel that carries one message byte and its flags per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlbh_byte_if;

    logic                 valid;
    logic                 ready;
    mlbh_pkg::byte_t      data_byte;
    logic                 has_byte;
    logic                 end_of_message;

    modport source (
        output valid,
        output data_byte,
        output has_byte,
        output end_of_message,
        input  ready
    );

    modport sink (
        input  valid,
        input  data_byte,
        input  has_byte,
        input  end_of_message,
        output ready
    );

endinterface

`default_nettype wire

### rtl/core/mlbh_digest_if.sv
// ----------------------------------------------------------------------------
// mlbh_digest_if: digest channel
// Valid/ready channel that carries one 256-bit digest as four lanes per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlbh_digest_if;

    logic                 valid;
    logic                 ready;
    mlbh_pkg::lane_t      digest_lane0;
    mlbh_pkg::lane_t      digest_lane1;
    mlbh_pkg::lane_t      digest_lane2;
    mlbh_pkg::lane_t      digest_lane3;

    modport source (
        output valid,
        output digest_lane0,
        output digest_lane1,
        output digest_lane2,
        output digest_lane3,
        input  ready
    );

    modport sink (
        input  valid,
        input  digest_lane0,
        input  digest_lane1,
        input  digest_lane2,
        input  digest_lane3,
        output ready
    );

endinterface

`default_nettype wire

### rtl/core/mlbh_lane_step.sv
// ----------------------------------------------------------------------------
// mlbh_lane_step: one hash lane update
// XOR in the offset byte, multiply by the lane prime as shift plus small
// constant product, then fold the upper bits down.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbh_lane_step #(
    parameter int unsigned LANE_IDX = 0
) (
    input  wire mlbh_pkg::lane_t lane,
    input  wire mlbh_pkg::byte_t data_byte,
    output mlbh_pkg::lane_t      lane_next
);
    import mlbh_pkg::*;

    localparam lane_t LaneAdd   = lane_t'(LaneAddStep * LANE_IDX);
    localparam lane_t LanePrime = PrimeLow + lane_t'(2 * LANE_IDX);

    lane_t mixed;
    lane_t product;

    assign mixed     = lane ^ (lane_t'(data_byte) + LaneAdd);
    assign product   = (mixed << PrimeShift) + (mixed * LanePrime);
    assign lane_next = product ^ (product >> FoldShift);

endmodule

`default_nettype wire

### rtl/core/mlbh_out_skid.sv
// ----------------------------------------------------------------------------
// mlbh_out_skid: digest output register with skid stage
// Two-entry output buffer; input side stays open while one digest waits.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbh_out_skid (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire mlbh_pkg::digest_t push_digest,
    output logic                   space,
    mlbh_digest_if.source          digest
);
    import mlbh_pkg::*;

    logic    out_valid_reg;
    digest_t out_data_reg;
    logic    skid_valid_reg;
    digest_t skid_data_reg;
    logic    out_free;

    assign out_free = !out_valid_reg || digest.ready;
    assign space    = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_digest;
        end
        else if (push)
        begin
            skid_data_reg <= push_digest;
        end
    end

    assign digest.valid        = out_valid_reg;
    assign digest.digest_lane0 = out_data_reg[0];
    assign digest.digest_lane1 = out_data_reg[1];
    assign digest.digest_lane2 = out_data_reg[2];
    assign digest.digest_lane3 = out_data_reg[3];

endmodule

`default_nettype wire

### rtl/core/multi_lane_byte_hash_256_unit.sv
// ----------------------------------------------------------------------------
// multi_lane_byte_hash_256_unit: four-lane byte hash with 256-bit digest
//
// byte_stream takes one beat per message byte (has_byte = 1) and marks the
// last beat with end_of_message; a beat with has_byte = 0 and the end flag
// finishes a message, an empty one included. digest gives one beat per
// message with lanes 0 to 3; lanes at or above LANE_COUNT read as zero.
// A beat is taken whenever ready is high: each lane update is one constant
// multiply with XOR and shift between the lane registers, so throughput is one
// byte per cycle while ready is high. Each digest is registered at the output.
// At reset the lanes load their start values and both output entries empty.
// When digest stalls, one more digest parks in the skid stage; byte_stream
// keeps taking byte beats until that second digest fills the skid stage,
// then ready drops until digest takes a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_lane_byte_hash_256_unit #(
    parameter int unsigned LANE_COUNT = 4
) (
    input  wire           clk,
    input  wire           rst_n,
    mlbh_byte_if.sink     byte_stream,
    mlbh_digest_if.source digest
);
    import mlbh_pkg::*;

    logic    accept;
    logic    space;
    logic    push;
    digest_t push_digest;
    lane_t   lanes_reg [LANE_COUNT];

    assign byte_stream.ready = space;
    assign accept            = byte_stream.valid && space;
    assign push              = accept && byte_stream.end_of_message;

    for (genvar j = 0; j < LaneMax; j++)
    begin : g_lane
        if (j < LANE_COUNT)
        begin : g_active
            lane_t stepped;
            lane_t lane_next;

            mlbh_lane_step #(
                .LANE_IDX (j)
            ) u_step (
                .lane      (lanes_reg[j]),
                .data_byte (byte_stream.data_byte),
                .lane_next (stepped)
            );

            assign lane_next      = byte_stream.has_byte ? stepped : lanes_reg[j];
            assign push_digest[j] = lane_next;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    lanes_reg[j] <= LaneStart[j];
                end
                else if (accept)
                begin
                    lanes_reg[j] <= byte_stream.end_of_message ? LaneStart[j] : lane_next;
                end
            end
        end
        else
        begin : g_absent
            assign push_digest[j] = '0;
        end
    end

    mlbh_out_skid u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_digest (push_digest),
        .space       (space),
        .digest      (digest)
    );

endmodule

`default_nettype wire

### rtl/core/mlbh_checker.sv
// ----------------------------------------------------------------------------
// mlbh_checker: port-level checks of the byte hash unit
// Output buffering and back-pressure rules, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mlbh_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_ready,
    input wire                  out_valid,
    input wire                  out_ready,
    input wire mlbh_pkg::lane_t lane0,
    input wire mlbh_pkg::lane_t lane1,
    input wire mlbh_pkg::lane_t lane2,
    input wire mlbh_pkg::lane_t lane3
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("digest valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lane0) && $stable(lane1)
            && $stable(lane2) && $stable(lane3))
        else $error("stalled digest beat changed");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready && in_valid))
        else $error("byte_stream ready dropped without a stalled digest");

    a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("byte_stream blocked with no digest pending");

endmodule

bind multi_lane_byte_hash_256_unit mlbh_checker u_mlbh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_stream.valid),
    .in_ready  (byte_stream.ready),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .lane0     (digest.digest_lane0),
    .lane1     (digest.digest_lane1),
    .lane2     (digest.digest_lane2),
    .lane3     (digest.digest_lane3)
);

`default_nettype wire
